@@ sv/ctc_pkg.sv @@
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 5;
    localparam int ROWCOL_W   = 4;
    localparam int SUM_W      = 64;
    localparam int ELEM_W     = 48;
    localparam int CUT_SHIFT  = 24;

    localparam logic KIND_DENSITY  = 1'b0;
    localparam logic KIND_INTEGRAL = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sd140737488355327;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -64'sd140737488355328;

    // Bookkeeping that travels with each integral through the MAC pipe.
    typedef struct packed {
        logic                first;       // opens a new (a,b) sum
        logic                last_inner;  // closes the (a,b) sum
        logic                last_mat;    // (a,b) = (N-1,N-1)
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
    } item_tag_t;

endpackage

@@ sv/ctc_density_mem.sv @@
`timescale 1ns / 1ps

module ctc_density_mem
    import ctc_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] density_mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    // Read data holds between reads; the MAC relies on that while stalled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            density_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= density_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ctc_seq.sv @@
`timescale 1ns / 1ps

module ctc_seq
    import ctc_pkg::*;
#(
    parameter int MAX_ORBITALS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [COUNT_W-1:0]                    cfg_count,
    input  logic                                  accept,
    input  logic                                  kind,
    input  logic [INDEX_W-1:0]                    index,
    output logic                                  mem_we,
    output logic [$clog2(MAX_ORBITALS*MAX_ORBITALS)-1:0] mem_waddr,
    output logic                                  mem_re,
    output logic [$clog2(MAX_ORBITALS*MAX_ORBITALS)-1:0] mem_raddr,
    output item_tag_t                             tag
);

    localparam int AW    = $clog2(MAX_ORBITALS * MAX_ORBITALS);
    localparam int NW    = $clog2(MAX_ORBITALS + 1);
    localparam int NNW   = $clog2(MAX_ORBITALS * MAX_ORBITALS + 1);
    localparam int RW    = $clog2(MAX_ORBITALS);
    localparam int XW    = NW + COUNT_W;
    localparam int CW    = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int RST_N = (MAX_ORBITALS < 16) ? MAX_ORBITALS : 16;

    logic [RW-1:0]  n_m1_reg,  n_m1_next;
    logic [AW-1:0]  nn_m1_reg, nn_m1_next;
    logic [AW-1:0]  pos_reg,   pos_next;
    logic [RW-1:0]  row_reg,   row_next;
    logic [RW-1:0]  col_reg,   col_next;

    logic [XW-1:0]  cnt_x;
    logic [NW-1:0]  n_new;
    logic [NNW-1:0] nn_new;
    logic           integral;
    logic           last_inner;
    logic           row_end;
    logic           col_end;

    // Clamp the count: zero means one, above the store means the store size.
    always_comb
    begin
        cnt_x = XW'(cfg_count);
        if (cnt_x == '0)
        begin
            n_new = NW'(1);
        end
        else if (cnt_x > XW'(MAX_ORBITALS))
        begin
            n_new = NW'(MAX_ORBITALS);
        end
        else
        begin
            n_new = NW'(cnt_x);
        end
        nn_new     = NNW'(n_new) * NNW'(n_new);
        n_m1_next  = RW'(n_new - NW'(1));
        nn_m1_next = AW'(nn_new - NNW'(1));
    end

    assign integral   = accept && (kind == KIND_INTEGRAL);
    assign last_inner = (pos_reg == nn_m1_reg);
    assign row_end    = (row_reg == n_m1_reg);
    assign col_end    = (col_reg == n_m1_reg);

    always_comb
    begin
        pos_next = pos_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            pos_next = '0;
            row_next = '0;
            col_next = '0;
        end
        else if (integral)
        begin
            if (last_inner)
            begin
                pos_next = '0;
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_end ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + RW'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_m1_reg  <= RW'(RST_N - 1);
            nn_m1_reg <= AW'(RST_N * RST_N - 1);
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_m1_reg  <= n_m1_next;
                nn_m1_reg <= nn_m1_next;
            end
            pos_reg <= pos_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Loads at or past N*N are dropped.
    assign mem_we    = accept && (kind == KIND_DENSITY) && (CW'(index) <= CW'(nn_m1_reg));
    assign mem_waddr = AW'(index);
    assign mem_re    = integral;
    assign mem_raddr = pos_reg;

    always_comb
    begin
        tag.first      = (pos_reg == '0);
        tag.last_inner = last_inner;
        tag.last_mat   = row_end && col_end;
        tag.row        = ROWCOL_W'(row_reg);
        tag.col        = ROWCOL_W'(col_reg);
    end

endmodule

@@ sv/ctc_mac.sv @@
`timescale 1ns / 1ps

module ctc_mac
    import ctc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [VALUE_W-1:0] value,
    input  item_tag_t          tag,
    input  logic [VALUE_W-1:0] density,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ROWCOL_W-1:0] out_row,
    output logic [ROWCOL_W-1:0] out_col,
    output logic [ELEM_W-1:0]  out_value,
    output logic               out_sat,
    output logic               out_last
);

    // Stage A: integral value beside the density word read from the store.
    logic                      a_valid_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    item_tag_t                 a_tag_reg;
    // Stage B: full product.
    logic                      b_valid_reg;
    logic signed [SUM_W-1:0]   b_prod_reg;
    item_tag_t                 b_tag_reg;
    // Stage C: running sum; valid only when it holds a finished element.
    logic                      c_valid_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    item_tag_t                 c_tag_reg;
    // Stage D: saturated result on the output.
    logic                      d_valid_reg;
    logic [ELEM_W-1:0]         d_value_reg;
    logic                      d_sat_reg;
    logic                      d_last_reg;
    logic [ROWCOL_W-1:0]       d_row_reg;
    logic [ROWCOL_W-1:0]       d_col_reg;

    logic d_free, c_move, c_free, b_move, b_free, a_move, a_free;
    logic signed [SUM_W-1:0] cut;
    logic sat_hi, sat_lo;

    assign d_free = !d_valid_reg || out_ready;
    assign c_move = c_valid_reg && d_free;
    assign c_free = !c_valid_reg || c_move;
    assign b_move = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || b_move;
    assign a_move = a_valid_reg && b_free;
    assign a_free = !a_valid_reg || a_move;

    // Arithmetic shift right floors, as the cut to Q16.24 requires.
    assign cut      = b_prod_reg >>> CUT_SHIFT;
    assign sum_next = (b_tag_reg.first ? '0 : sum_reg) + cut;
    assign sat_hi   = sum_reg > SUM_MAX;
    assign sat_lo   = sum_reg < SUM_MIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_move)
            begin
                c_valid_reg <= b_tag_reg.last_inner;
            end
            else if (c_move)
            begin
                c_valid_reg <= 1'b0;
            end

            if (c_move)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                d_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_value_reg <= $signed(value);
            a_tag_reg   <= tag;
        end
        if (a_move)
        begin
            b_prod_reg <= SUM_W'(a_value_reg) * SUM_W'($signed(density));
            b_tag_reg  <= a_tag_reg;
        end
        if (b_move)
        begin
            sum_reg   <= sum_next;
            c_tag_reg <= b_tag_reg;
        end
        if (c_move)
        begin
            priority if (sat_hi)
            begin
                d_value_reg <= SUM_MAX[ELEM_W-1:0];
            end
            else if (sat_lo)
            begin
                d_value_reg <= SUM_MIN[ELEM_W-1:0];
            end
            else
            begin
                d_value_reg <= sum_reg[ELEM_W-1:0];
            end
            d_sat_reg  <= sat_hi || sat_lo;
            d_last_reg <= c_tag_reg.last_mat;
            d_row_reg  <= c_tag_reg.row;
            d_col_reg  <= c_tag_reg.col;
        end
    end

    assign ready     = a_free;
    assign out_valid = d_valid_reg;
    assign out_row   = d_row_reg;
    assign out_col   = d_col_reg;
    assign out_value = d_value_reg;
    assign out_sat   = d_sat_reg;
    assign out_last  = d_last_reg;

endmodule

@@ sv/coulomb_tensor_contraction_top.sv @@
`timescale 1ns / 1ps

// Coulomb matrix build: J(a,b) = sum over c,d of D(c,d) * I(a,b,c,d), all values
// signed Q8.24. First load the density matrix with tuser = 0 transfers (tdata
// index c*N+d, loads at or past N*N are dropped), then stream integrals with
// tuser = 1 in (a,b,c,d) order, d fastest. After each run of N*N integrals the
// block emits one element with its row and column, summed from products floored
// to Q16.24 and saturated to Q24.24 (tuser flags the clip, tlast marks
// (N-1,N-1)). Throughput is one transfer per clock while s_tready is high,
// density load or integral; each transfer makes at most one write or one read
// of the density store. After its last integral, a result passes the stages
// store read, multiply, accumulate, saturate. Stalls on the result side are
// absorbed by the MAC stages before the input backs off. Writing orbital_count
// (0 acts as 1, values above MAX_ORBITALS clamp) restarts at element (0,0) and
// keeps the density; write it only while the block is idle. The density store
// is not cleared by reset, so every entry must be loaded before it is used.

module coulomb_tensor_contraction_top
    import ctc_pkg::*;
#(
    parameter int MAX_ORBITALS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,      // orbital_count

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,       // [7:0] element_index, [39:8] value
    input  logic         s_tuser,       // kind

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,       // [3:0] matrix_row, [7:4] matrix_col,
                                        // [55:8] element_value
    output logic         m_tuser,       // saturated
    output logic         m_tlast        // last_of_matrix
);

    localparam int DEPTH = MAX_ORBITALS * MAX_ORBITALS;
    localparam int AW    = $clog2(DEPTH);

    logic               in_xfer;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    item_tag_t          tag;
    logic [ROWCOL_W-1:0] out_row;
    logic [ROWCOL_W-1:0] out_col;
    logic [ELEM_W-1:0]  out_value;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;

    // Counters, density write decode and store addressing.
    ctc_seq #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_count (cfg_data),
        .accept    (in_xfer),
        .kind      (s_tuser),
        .index     (s_tdata[INDEX_W-1:0]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .tag       (tag)
    );

    // A load and a read never share a cycle, and a read in the cycle after a load
    // already sees the new word, so no forwarding is needed.
    ctc_density_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata[INDEX_W +: VALUE_W]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ctc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (mem_re),
        .value     (s_tdata[INDEX_W +: VALUE_W]),
        .tag       (tag),
        .density   (mem_rdata),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_value, out_col, out_row};

    // The density store is never written and read together.
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("density store written and read in one cycle");

    // The input backs off only when a result is held up downstream.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // A clipped result sits at one of the two range limits.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (out_value == SUM_MAX[ELEM_W-1:0] || out_value == SUM_MIN[ELEM_W-1:0]))
        else $error("saturated flag without a limit value");

endmodule
